// File: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define PSU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// property must never hold outside reset
`define PSU_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("forbidden condition seen");
`else
`define PSU_ASSERT(lbl, clk, rstn, prop)
`define PSU_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// File: rtl/psu_pkg.sv
package psu_pkg;

    localparam int PARTICLES = 64;
    localparam int WORDS_PER = 64;
    localparam int P_W       = $clog2(PARTICLES);
    localparam int ADDR_W    = P_W + $clog2(WORDS_PER);
    localparam int DEPTH     = 2 ** ADDR_W;
    localparam int W_SAVED   = 37;
    localparam int N_SAVE    = 20;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SAVE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic signed [31:0] COL_MAX  = 32'sh00FF0000;
    localparam logic signed [31:0] Q_MAX    = 32'sh7FFFFFFF;
    localparam logic [41:0]        DTS_BIAS  = 42'd500;
    // ceil(2^52 / 1000): exact quotient by 1000 for dividends below 2^42
    localparam logic [43:0]        RECIP_1000  = 44'd4503599627371;
    localparam int                 RECIP_SHIFT = 52;

    // live word of each saved slot
    localparam logic [5:0] SAVE_LIVE [N_SAVE] = '{
        6'd7, 6'd8, 6'd9, 6'd10, 6'd16, 6'd17, 6'd18, 6'd19, 6'd13, 6'd14,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd34, 6'd35};

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh7FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sh80000000) begin
            r = -32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b);
        return sat32(s);
    endfunction

    // round to nearest, ties up, then drop 16 fraction bits
    function automatic logic signed [31:0] qrnd(input logic signed [63:0] p);
        logic signed [65:0] s;
        s = (66'(p) + 66'sh8000) >>> 16;
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] clampc(input logic signed [31:0] c);
        logic signed [31:0] r;
        if (c < 0) begin
            r = 32'sh0;
        end else if (c > COL_MAX) begin
            r = COL_MAX;
        end else begin
            r = c;
        end
        return r;
    endfunction

    function automatic logic [7:0] col_int(input logic signed [31:0] c);
        logic [7:0] r;
        if (c < 0) begin
            r = 8'd0;
        end else if (c > COL_MAX) begin
            r = 8'd255;
        end else begin
            r = c[23:16];
        end
        return r;
    endfunction

endpackage

// File: rtl/psu_in_if.sv
interface psu_in_if;
    import psu_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [5:0]        particle;
    logic [5:0]        word_select;
    logic signed [31:0] word_value;
    logic [30:0]       dt;
    modport source (output valid, kind, particle, word_select, word_value, dt,
                    input ready);
    modport sink   (input valid, kind, particle, word_select, word_value, dt,
                    output ready);
endinterface

// File: rtl/psu_out_if.sv
interface psu_out_if;
    import psu_pkg::*;
    logic               valid;
    logic               ready;
    logic [5:0]         particle_out;
    logic               active;
    logic               visible;
    logic               respawned;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] depth;
    logic [31:0]        colour_rgba;
    modport source (output valid, particle_out, active, visible, respawned, pos_x,
                    pos_y, angle, scale_x, scale_y, depth, colour_rgba,
                    input ready);
    modport sink   (input valid, particle_out, active, visible, respawned, pos_x,
                    pos_y, angle, scale_x, scale_y, depth, colour_rgba,
                    output ready);
endinterface

// File: rtl/particle_state_update_unit.sv
// particle state update unit
// i_in carries one transaction per item: kind write word, save spawn values or tick.
// o_out carries one result per tick: flags, position, angle, scale, depth, colour.
// i_cfg_wr_en/i_cfg_wr_data write frame_ms; write only while the block is idle.
// state is one 4096 x 32 synchronous ram, 64 words per particle.
// a write-word item goes straight to the ram in the cycle it is accepted.
// a save item streams the particle's words into a local shift line over the
// single ram port, copies the live words to the saved slots and writes all back.
// a tick loads the words (the scaled time is a reciprocal multiply by 1/1000 in 4
// steps alongside), then runs a life step, 21 multiplies on the shared 32x32
// multiplier, each a multiply and a product step, an end-of-life step, an output
// step and the write back; a tick that does not integrate skips the multiplies and
// the end-of-life step. only one item is in work at a time.
// the result register frees the input side: a tick only waits in its output step
// while the previous result has not been taken.
// after reset the ram is cleared to zero by a pass over all 4096 words; no item is
// accepted during that pass, and frame_ms returns to 16.
module particle_state_update_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psu_in_if.sink         i_in,
    psu_out_if.source      o_out,
    input  logic           i_cfg_wr_en,
    input  logic [9:0]     i_cfg_wr_data
);
    import psu_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_SAVE = 4'd3;
    localparam logic [3:0] S_LIFE = 4'd4;
    localparam logic [3:0] S_MULA = 4'd5;
    localparam logic [3:0] S_MULB = 4'd6;
    localparam logic [3:0] S_END  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;

    localparam logic [4:0] OP_PX  = 5'd0;
    localparam logic [4:0] OP_VX  = 5'd1;
    localparam logic [4:0] OP_PY  = 5'd2;
    localparam logic [4:0] OP_VYD = 5'd3;
    localparam logic [4:0] OP_GRV = 5'd4;
    localparam logic [4:0] OP_ANG = 5'd5;
    localparam logic [4:0] OP_AV  = 5'd6;
    localparam logic [4:0] OP_SX  = 5'd7;
    localparam logic [4:0] OP_SVX = 5'd8;
    localparam logic [4:0] OP_SY  = 5'd9;
    localparam logic [4:0] OP_SVY = 5'd10;
    localparam logic [4:0] OP_CR  = 5'd11;
    localparam logic [4:0] OP_CVR = 5'd12;
    localparam logic [4:0] OP_CG  = 5'd13;
    localparam logic [4:0] OP_CVG = 5'd14;
    localparam logic [4:0] OP_CB  = 5'd15;
    localparam logic [4:0] OP_CVB = 5'd16;
    localparam logic [4:0] OP_CA  = 5'd17;
    localparam logic [4:0] OP_CVA = 5'd18;
    localparam logic [4:0] OP_D   = 5'd19;
    localparam logic [4:0] OP_DV  = 5'd20;

    logic [3:0]          r_state;
    logic [ADDR_W:0]     r_clr;
    logic [6:0]          r_cnt;
    logic [4:0]          r_op;
    logic [1:0]          r_kind;
    logic [P_W-1:0]      r_p;
    logic [30:0]         r_dt;
    logic [9:0]          r_frame;
    logic [41:0]         r_x;
    logic [85:0]         r_acc;
    logic [2:0]          r_dcnt;
    logic                r_resp;
    logic                r_ovalid;
    logic signed [63:0]  r_prod;
    logic signed [31:0]  r_tmp;
    logic [31:0]         r_w [WORDS_PER];
    logic [31:0]         r_rdata;
    logic [31:0]         mem [DEPTH];

    logic                in_acc;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [31:0]         mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [10:0]         recip_chunk;
    logic [52:0]         recip_part;
    logic [33:0]         quot;
    logic signed [31:0]  dts;
    logic signed [31:0]  dt_s;
    logic signed [31:0]  lt_new;
    logic signed [31:0]  end_t;
    logic signed [31:0]  op_a;
    logic signed [31:0]  op_b;
    logic signed [31:0]  m;
    logic                out_free;
    logic                p_ok;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign p_ok       = ({1'b0, i_in.particle} < 7'(PARTICLES));
    assign out_free   = !r_ovalid || o_out.ready;
    assign dt_s       = {1'b0, r_dt};
    assign quot       = r_acc[RECIP_SHIFT +: 34];
    assign dts        = (|quot[33:31]) ? Q_MAX : {1'b0, quot[30:0]};
    assign lt_new     = qadd(r_w[2], dts);
    assign end_t      = qadd(r_w[4], r_w[3]);
    assign m          = qrnd(r_prod);
    assign recip_part = 53'(r_x) * 53'(recip_chunk);

    // reciprocal slice for each step, most significant first
    always_comb begin
        case (r_dcnt[1:0])
            2'd0:    recip_chunk = RECIP_1000[43:33];
            2'd1:    recip_chunk = RECIP_1000[32:22];
            2'd2:    recip_chunk = RECIP_1000[21:11];
            default: recip_chunk = RECIP_1000[10:0];
        endcase
    end

    // ram write port: clear pass, single word write, write back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr[ADDR_W-1:0];
            end
            S_IDLE: begin
                mem_we    = in_acc && p_ok && (i_in.kind == KIND_WRITE);
                mem_waddr = {i_in.particle[P_W-1:0], i_in.word_select};
                mem_wdata = i_in.word_value;
            end
            S_WB: begin
                mem_we    = 1'b1;
                mem_waddr = {r_p, r_cnt[5:0]};
                mem_wdata = r_w[0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr = {r_p, r_cnt[5:0]};

    // state ram, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = dt_s;
        case (r_op)
            OP_PX:  op_a = r_w[9];
            OP_VX:  begin op_a = r_w[9];  op_b = r_w[11]; end
            OP_PY:  op_a = r_w[10];
            OP_VYD: begin op_a = r_w[10]; op_b = r_w[12]; end
            OP_GRV: op_a = r_w[6];
            OP_ANG: op_a = r_w[14];
            OP_AV:  begin op_a = r_w[14]; op_b = r_w[15]; end
            OP_SX:  op_a = r_w[18];
            OP_SVX: begin op_a = r_w[18]; op_b = r_w[20]; end
            OP_SY:  op_a = r_w[19];
            OP_SVY: begin op_a = r_w[19]; op_b = r_w[21]; end
            OP_CR:  op_a = r_w[26];
            OP_CVR: begin op_a = r_w[26]; op_b = r_w[30]; end
            OP_CG:  op_a = r_w[27];
            OP_CVG: begin op_a = r_w[27]; op_b = r_w[31]; end
            OP_CB:  op_a = r_w[28];
            OP_CVB: begin op_a = r_w[28]; op_b = r_w[32]; end
            OP_CA:  op_a = r_w[29];
            OP_CVA: begin op_a = r_w[29]; op_b = r_w[33]; end
            OP_D:   op_a = r_w[35];
            OP_DV:  begin op_a = r_w[35]; op_b = r_w[36]; end
            default: op_a = '0;
        endcase
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_op    <= '0;
            r_frame <= 10'd16;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame <= i_cfg_wr_data;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (ADDR_W+1)'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc && p_ok &&
                        (i_in.kind == KIND_SAVE || i_in.kind == KIND_TICK)) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'(WORDS_PER)) begin
                        r_cnt   <= '0;
                        r_state <= (r_kind == KIND_SAVE) ? S_SAVE : S_LIFE;
                    end
                end
                S_SAVE: r_state <= S_WB;
                S_LIFE: begin
                    r_op <= OP_PX;
                    if (r_w[0] == '0 || $signed(lt_new) < $signed(r_w[3])) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MULA;
                    end
                end
                S_MULA: r_state <= S_MULB;
                S_MULB: begin
                    r_op    <= r_op + 1'b1;
                    r_state <= (r_op == OP_DV) ? S_END : S_MULA;
                end
                S_END: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'(WORDS_PER - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item capture and scaled time, reciprocal multiply 11 bits a step
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_in.kind;
            r_p    <= i_in.particle[P_W-1:0];
            r_dt   <= i_in.dt;
            r_x    <= 42'(i_in.dt) * 42'(r_frame) + DTS_BIAS;
            r_acc  <= '0;
            r_dcnt <= '0;
        end else if (r_state == S_LOAD && r_dcnt != 3'd4) begin
            r_dcnt <= r_dcnt + 1'b1;
            r_acc  <= {r_acc[74:0], 11'b0} + 86'(recip_part);
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (r_state == S_MULA) begin
            r_prod <= op_a * op_b;
        end
    end

    // local copy of the particle words
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (r_cnt != '0) begin
                    for (int k = 0; k < WORDS_PER - 1; k++) begin
                        r_w[k] <= r_w[k+1];
                    end
                    r_w[WORDS_PER-1] <= r_rdata;
                end
            end
            S_WB: begin
                for (int k = 0; k < WORDS_PER - 1; k++) begin
                    r_w[k] <= r_w[k+1];
                end
            end
            S_SAVE: begin
                for (int k = 0; k < N_SAVE; k++) begin
                    r_w[W_SAVED+k] <= r_w[SAVE_LIVE[k]];
                end
            end
            S_LIFE: begin
                r_resp <= 1'b0;
                if (r_w[0] == '0) begin
                    r_w[1] <= '0;
                end else begin
                    r_w[2] <= lt_new;
                    r_w[1] <= ($signed(lt_new) < $signed(r_w[3])) ? 32'd0 : 32'd1;
                end
            end
            S_MULB: begin
                case (r_op)
                    OP_PX:  r_w[7]  <= qadd(r_w[7], m);
                    OP_VX:  r_w[9]  <= m;
                    OP_PY:  r_w[8]  <= qadd(r_w[8], m);
                    OP_VYD: r_tmp   <= m;
                    OP_GRV: r_w[10] <= qadd(r_tmp, m);
                    OP_ANG: r_w[13] <= qadd(r_w[13], m);
                    OP_AV:  r_w[14] <= m;
                    OP_SX:  r_w[16] <= qadd(r_w[16], m);
                    OP_SVX: r_w[18] <= m;
                    OP_SY:  r_w[17] <= qadd(r_w[17], m);
                    OP_SVY: r_w[19] <= m;
                    OP_CR:  r_w[22] <= clampc(qadd(r_w[22], m));
                    OP_CVR: r_w[26] <= m;
                    OP_CG:  r_w[23] <= clampc(qadd(r_w[23], m));
                    OP_CVG: r_w[27] <= m;
                    OP_CB:  r_w[24] <= clampc(qadd(r_w[24], m));
                    OP_CVB: r_w[28] <= m;
                    OP_CA:  r_w[25] <= clampc(qadd(r_w[25], m));
                    OP_CVA: r_w[29] <= m;
                    OP_D:   r_w[34] <= qadd(r_w[34], m);
                    OP_DV:  r_w[35] <= m;
                    default: r_tmp  <= r_tmp;
                endcase
            end
            S_END: begin
                // end of life span: wrap time, count lives, deactivate on the last life or else restore spawn values
                if ($signed(r_w[2]) >= end_t) begin
                    r_w[2] <= sat32(66'($signed(r_w[2])) - 66'(end_t));
                    r_w[3] <= '0;
                    if ($signed(r_w[5]) == 32'sd1) begin
                        r_w[0] <= '0;
                        r_w[1] <= '0;
                    end else begin
                        if ($signed(r_w[5]) > 32'sd1) begin
                            r_w[5] <= r_w[5] - 32'd1;
                        end
                        for (int k = 0; k < N_SAVE; k++) begin
                            r_w[SAVE_LIVE[k]] <= r_w[W_SAVED+k];
                        end
                        r_resp <= 1'b1;
                    end
                end
            end
            default: r_resp <= r_resp;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            o_out.particle_out <= 6'(r_p);
            o_out.active       <= (r_w[0] != '0);
            o_out.visible      <= (r_w[1] != '0);
            o_out.respawned    <= r_resp;
            o_out.pos_x        <= r_w[7];
            o_out.pos_y        <= r_w[8];
            o_out.angle        <= r_w[13];
            o_out.scale_x      <= r_w[16];
            o_out.scale_y      <= r_w[17];
            o_out.depth        <= r_w[34];
            o_out.colour_rgba  <= {col_int(r_w[22]), col_int(r_w[23]),
                                   col_int(r_w[24]), col_int(r_w[25])};
        end
    end

    assign o_out.valid = r_ovalid;

`include "assert_macros.svh"

    // ram is written only by the clear pass, a word write or the write back
    `PSU_ASSERT(a_mem_we_state, i_clk, i_rst_n, !mem_we || r_state == S_CLR || r_state == S_IDLE || r_state == S_WB)
    // a new result appears only from the output step
    `PSU_ASSERT(a_out_from_step, i_clk, i_rst_n, !$rose(r_ovalid) || $past(r_state) == S_OUT)
    // the multiply sequence never runs past its last operation
    `PSU_NEVER(a_op_range, i_clk, i_rst_n, (r_state == S_MULA || r_state == S_MULB) && r_op > OP_DV)

endmodule
